/* rtl/core/triangle_tangent_from_uv_defines.svh */
// Assertion macros shared by the triangle tangent RTL.
`ifndef TRIANGLE_TANGENT_FROM_UV_DEFINES_SVH
`define TRIANGLE_TANGENT_FROM_UV_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define TTUV_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ttuv assertion failed");
// Next-cycle implication, checked out of reset.
`define TTUV_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ttuv assertion failed");
`else
`define TTUV_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define TTUV_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/ttuv_pkg.sv */
// Shared types and constants for the triangle tangent block.
`timescale 1ns / 1ps
package ttuv_pkg;

	// position of the next vertex within its triangle
	localparam logic [1:0] SLOT_FIRST  = 2'd0;
	localparam logic [1:0] SLOT_SECOND = 2'd1;
	localparam logic [1:0] SLOT_THIRD  = 2'd2;

	// one complete triangle, handed from front to back
	typedef struct packed {
		logic [23:0]        idx0;
		logic [23:0]        idx1;
		logic [23:0]        idx2;
		logic signed [32:0] e1_x;
		logic signed [32:0] e1_y;
		logic signed [32:0] e1_z;
		logic signed [32:0] e2_x;
		logic signed [32:0] e2_y;
		logic signed [32:0] e2_z;
		logic signed [32:0] du1;
		logic signed [32:0] dv1;
		logic signed [32:0] du2;
		logic signed [32:0] dv2;
	} tri_t;

endpackage

/* rtl/core/ttuv_front.sv */
// Vertex intake: holds corners 0 and 1, forms edges and UV deltas on corner 2.
`timescale 1ns / 1ps
module ttuv_front import ttuv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [23:0] vertex_index,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] pos_z,
	input  logic [31:0] tex_u,
	input  logic [31:0] tex_v,
	output logic        push_valid,
	input  logic        push_ready,
	output tri_t        push_item
);

	logic [1:0]  slot_q;
	logic [23:0] idx0_q, idx1_q;
	logic [31:0] p0x_q, p0y_q, p0z_q, p1x_q, p1y_q, p1z_q;
	logic [31:0] t0u_q, t0v_q, t1u_q, t1v_q;
	logic        accept;

	function automatic logic signed [32:0] sdiff(input logic [31:0] a, input logic [31:0] b);
		sdiff = $signed({a[31], a}) - $signed({b[31], b});
	endfunction

	// third corner waits only for queue space
	assign in_ready   = (slot_q != SLOT_THIRD) || push_ready;
	assign accept     = in_valid && in_ready;
	assign push_valid = in_valid && (slot_q == SLOT_THIRD) && push_ready;

	// corner counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= SLOT_FIRST;
		end else if (accept) begin
			unique case (slot_q)
				SLOT_SECOND: slot_q <= SLOT_THIRD;
				SLOT_THIRD:  slot_q <= SLOT_FIRST;
				default:     slot_q <= SLOT_SECOND;
			endcase
		end
	end

	// held corners
	always_ff @(posedge clk) begin
		if (accept && slot_q == SLOT_SECOND) begin
			idx1_q <= vertex_index;
			p1x_q  <= pos_x;
			p1y_q  <= pos_y;
			p1z_q  <= pos_z;
			t1u_q  <= tex_u;
			t1v_q  <= tex_v;
		end else if (accept && slot_q != SLOT_THIRD) begin
			idx0_q <= vertex_index;
			p0x_q  <= pos_x;
			p0y_q  <= pos_y;
			p0z_q  <= pos_z;
			t0u_q  <= tex_u;
			t0v_q  <= tex_v;
		end
	end

	// edges and UV deltas, exact in 33 bits
	always_comb begin
		push_item.idx0 = idx0_q;
		push_item.idx1 = idx1_q;
		push_item.idx2 = vertex_index;
		push_item.e1_x = sdiff(p1x_q, p0x_q);
		push_item.e1_y = sdiff(p1y_q, p0y_q);
		push_item.e1_z = sdiff(p1z_q, p0z_q);
		push_item.e2_x = sdiff(pos_x, p0x_q);
		push_item.e2_y = sdiff(pos_y, p0y_q);
		push_item.e2_z = sdiff(pos_z, p0z_q);
		push_item.du1  = sdiff(t1u_q, t0u_q);
		push_item.dv1  = sdiff(t1v_q, t0v_q);
		push_item.du2  = sdiff(tex_u, t0u_q);
		push_item.dv2  = sdiff(tex_v, t0v_q);
	end

endmodule

/* rtl/core/ttuv_queue.sv */
// Small triangle queue between intake and tangent unit.
`timescale 1ns / 1ps
`include "triangle_tangent_from_uv_defines.svh"
module ttuv_queue import ttuv_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  tri_t push_item,
	output logic pop_valid,
	input  logic pop_ready,
	output tri_t pop_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tri_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	`TTUV_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(DEPTH))
	`TTUV_ASSERT_IMP(a_front_respects_full, clk, arst_n, push_valid, push_ready)
	`TTUV_ASSERT_NXT(a_push_fills, clk, arst_n, push && !pop, pop_valid)

endmodule

/* rtl/core/ttuv_back.sv */
// Tangent unit: shared multiplier, normalize shift, square root, divide.
`timescale 1ns / 1ps
`include "triangle_tangent_from_uv_defines.svh"
module ttuv_back import ttuv_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  tri_t               pop_item,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [23:0]        first_index,
	output logic [23:0]        second_index,
	output logic [23:0]        third_index,
	output logic signed [15:0] tangent_x,
	output logic signed [15:0] tangent_y,
	output logic signed [15:0] tangent_z,
	output logic               degenerate
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_MUL  = 8'b0000_0010,
		ST_FIX  = 8'b0000_0100,
		ST_NORM = 8'b0000_1000,
		ST_SQR  = 8'b0001_0000,
		ST_SQRT = 8'b0010_0000,
		ST_DIV  = 8'b0100_0000,
		ST_OUT  = 8'b1000_0000
	} state_t;

	localparam logic [4:0]  MUL_LAST  = 5'd8;
	localparam logic [4:0]  SQR_LAST  = 5'd3;
	localparam logic [4:0]  SQRT_LAST = 5'd30;
	localparam logic [4:0]  DIV_LAST  = 5'd14;
	localparam logic [14:0] Q_ONE     = 15'd16384;

	state_t              state_q;
	logic [4:0]          cnt_q;
	tri_t                item_q;
	logic signed [32:0]  opa, opb;
	logic signed [65:0]  prod_q;
	logic                mac_vld_q;
	logic [2:0]          mac_step_q;
	logic signed [66:0]  acc_q [4];
	logic [65:0]         mag_q [3];
	logic                neg_q [3];
	logic                degen_q;
	logic [29:0]         sq_src;
	logic [59:0]         sq_q;
	logic [61:0]         sum_q;
	logic [33:0]         rem_q, rem_sh, trial, rem_nx;
	logic [30:0]         root_q, root_nx, n_fix;
	logic                root_ge;
	logic [45:0]         dsh_q;
	logic [45:0]         drem_q [3];
	logic [14:0]         quo_q [3];
	logic [65:0]         abs_t [3];
	logic [65:0]         or_all;
	logic                det_zero, t_zero, out_load;
	logic [15:0]         tan_val [3];

	assign pop_ready = (state_q == ST_IDLE);
	assign out_load  = (state_q == ST_OUT) && (!out_valid || out_ready);

	// operand select for the shared 33x33 multiplier
	always_comb begin
		unique case (cnt_q[2:0])
			3'd0:    begin opa = item_q.du1; opb = item_q.dv2;  end
			3'd1:    begin opa = item_q.du2; opb = item_q.dv1;  end
			3'd2:    begin opa = item_q.dv2; opb = item_q.e1_x; end
			3'd3:    begin opa = item_q.dv1; opb = item_q.e2_x; end
			3'd4:    begin opa = item_q.dv2; opb = item_q.e1_y; end
			3'd5:    begin opa = item_q.dv1; opb = item_q.e2_y; end
			3'd6:    begin opa = item_q.dv2; opb = item_q.e1_z; end
			default: begin opa = item_q.dv1; opb = item_q.e2_z; end
		endcase
	end

	// magnitudes and zero tests of det and tangent
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			abs_t[k] = acc_q[k + 1][66] ? 66'(-acc_q[k + 1]) : acc_q[k + 1][65:0];
		end
		det_zero = (acc_q[0] == '0);
		t_zero   = (acc_q[1] == '0) && (acc_q[2] == '0) && (acc_q[3] == '0);
		or_all   = mag_q[0] | mag_q[1] | mag_q[2];
	end

	// square source and one root digit per cycle
	always_comb begin
		sq_src  = (cnt_q[1:0] == 2'd0) ? mag_q[0][29:0] :
		          (cnt_q[1:0] == 2'd1) ? mag_q[1][29:0] : mag_q[2][29:0];
		rem_sh  = {rem_q[31:0], sum_q[61:60]};
		trial   = {1'b0, root_q, 2'b01};
		root_ge = (rem_sh >= trial);
		rem_nx  = root_ge ? rem_sh - trial : rem_sh;
		root_nx = {root_q[29:0], root_ge};
		n_fix   = (root_nx == '0) ? 31'd1 : root_nx;
	end

	// clamp and restore sign
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic [14:0] qc;
			qc = (quo_q[k] > Q_ONE) ? Q_ONE : quo_q[k];
			tan_val[k] = (neg_q[k] && qc != '0) ? 16'd0 - {1'b0, qc} : {1'b0, qc};
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			mac_vld_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			mac_vld_q <= (state_q == ST_MUL) && !cnt_q[3];
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (pop_valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (cnt_q == MUL_LAST) begin
						state_q <= ST_FIX;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FIX: begin
					cnt_q   <= '0;
					state_q <= (det_zero || t_zero) ? ST_OUT : ST_NORM;
				end
				ST_NORM: begin
					if (or_all[65:30] == '0) begin
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					if (cnt_q == SQR_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_SQRT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SQRT: begin
					if (cnt_q == SQRT_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (cnt_q == DIV_LAST) begin
						state_q <= ST_OUT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop_valid) begin
			item_q <= pop_item;
		end
		// product is registered, then accumulated in the next cycle
		prod_q     <= opa * opb;
		mac_step_q <= cnt_q[2:0];
		if (mac_vld_q) begin
			if (!mac_step_q[0]) begin
				acc_q[mac_step_q[2:1]] <= {prod_q[65], prod_q};
			end else begin
				acc_q[mac_step_q[2:1]] <= acc_q[mac_step_q[2:1]] - {prod_q[65], prod_q};
			end
		end
		case (state_q)
			ST_FIX: begin
				degen_q <= det_zero || t_zero;
				for (int k = 0; k < 3; k++) begin
					mag_q[k] <= abs_t[k];
					neg_q[k] <= acc_q[k + 1][66] ^ acc_q[0][66];
				end
			end
			ST_NORM: begin
				// coarse steps of eight, then single steps, all truncating
				for (int k = 0; k < 3; k++) begin
					if (or_all[65:38] != '0) begin
						mag_q[k] <= mag_q[k] >> 8;
					end else if (or_all[65:30] != '0) begin
						mag_q[k] <= mag_q[k] >> 1;
					end
				end
			end
			ST_SQR: begin
				sq_q <= sq_src * sq_src;
				if (cnt_q == 5'd1) begin
					sum_q <= 62'(sq_q);
				end else if (cnt_q != 5'd0) begin
					sum_q <= sum_q + 62'(sq_q);
				end
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_SQRT: begin
				sum_q  <= sum_q << 2;
				rem_q  <= rem_nx;
				root_q <= root_nx;
				if (cnt_q == SQRT_LAST) begin
					// numerator m*32768 + n, divisor 2n aligned to quotient bit 14
					dsh_q <= {n_fix, 15'd0};
					for (int k = 0; k < 3; k++) begin
						drem_q[k] <= {1'b0, mag_q[k][29:0], 15'd0} + 46'(n_fix);
						quo_q[k]  <= '0;
					end
				end
			end
			ST_DIV: begin
				dsh_q <= dsh_q >> 1;
				for (int k = 0; k < 3; k++) begin
					if (drem_q[k] >= dsh_q) begin
						drem_q[k] <= drem_q[k] - dsh_q;
						quo_q[k]  <= {quo_q[k][13:0], 1'b1};
					end else begin
						quo_q[k]  <= {quo_q[k][13:0], 1'b0};
					end
				end
			end
			default: ;
		endcase
		// output register
		if (out_load) begin
			first_index  <= item_q.idx0;
			second_index <= item_q.idx1;
			third_index  <= item_q.idx2;
			degenerate   <= degen_q;
			tangent_x    <= degen_q ? '0 : tan_val[0];
			tangent_y    <= degen_q ? '0 : tan_val[1];
			tangent_z    <= degen_q ? '0 : tan_val[2];
		end
	end

	`TTUV_ASSERT_IMP(a_degen_zero, clk, arst_n, out_valid && degenerate, tangent_x == '0 && tangent_y == '0 && tangent_z == '0)
	`TTUV_ASSERT_IMP(a_unit_nonzero, clk, arst_n, out_valid && !degenerate, tangent_x != '0 || tangent_y != '0 || tangent_z != '0)
	`TTUV_ASSERT_NXT(a_pop_starts, clk, arst_n, pop_valid && pop_ready, state_q == ST_MUL)

endmodule

/* rtl/core/triangle_tangent_from_uv.sv */
// Top level: per-triangle unit tangent from vertex positions and UVs.
//
//  channel  dir  handshake             payload
//  in       in   in_valid / in_ready   vertex_index, pos_xyz, tex_u, tex_v
//  out      out  out_valid / out_ready indices, tangent_xyz, degenerate
//
// Vertices 0 and 1 of a triangle are accepted without waiting; vertex 2 is taken
// when the triangle queue has room. Per triangle the tangent unit runs load,
// multiply, sign fix, normalize, square, 31-bit root, 15-bit divide and output
// steps, one triangle at a time; degenerate ones skip from sign fix to output.
// The root and divide loops set the throughput. Reset is asynchronous and empties
// the queue and the corner count. Output stalls back up through the queue.
`timescale 1ns / 1ps
module triangle_tangent_from_uv import ttuv_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [23:0]        vertex_index,
	input  logic [31:0]        pos_x,
	input  logic [31:0]        pos_y,
	input  logic [31:0]        pos_z,
	input  logic [31:0]        tex_u,
	input  logic [31:0]        tex_v,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [23:0]        first_index,
	output logic [23:0]        second_index,
	output logic [23:0]        third_index,
	output logic signed [15:0] tangent_x,
	output logic signed [15:0] tangent_y,
	output logic signed [15:0] tangent_z,
	output logic               degenerate
);

	logic push_valid, push_ready, pop_valid, pop_ready;
	tri_t push_item, pop_item;

	ttuv_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .vertex_index,
		.pos_x, .pos_y, .pos_z, .tex_u, .tex_v,
		.push_valid, .push_ready, .push_item
	);

	ttuv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk, .arst_n, .push_valid, .push_ready, .push_item,
		.pop_valid, .pop_ready, .pop_item
	);

	ttuv_back u_back (
		.clk, .arst_n, .pop_valid, .pop_ready, .pop_item,
		.out_valid, .out_ready, .first_index, .second_index, .third_index,
		.tangent_x, .tangent_y, .tangent_z, .degenerate
	);

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the per-triangle tangent block.
`timescale 1ns / 1ps
module testbench import ttuv_pkg::*; ;

	typedef struct {
		logic [23:0]        idx0, idx1, idx2;
		logic signed [15:0] tx, ty, tz;
		logic               degen;
	} tangent_result_t;

	logic               clk, arst_n;
	logic               in_valid, in_ready, out_valid, out_ready;
	logic [23:0]        vertex_index;
	logic [31:0]        pos_x, pos_y, pos_z, tex_u, tex_v;
	logic [23:0]        first_index, second_index, third_index;
	logic signed [15:0] tangent_x, tangent_y, tangent_z;
	logic               degenerate;

	tangent_result_t tangent_q[$];
	int              err_cnt;
	int              quiet_cycles;
	bit              idle_on;
	bit              hold_req;

	// corner state of the predictor
	logic [1:0]         corner;
	logic [23:0]        held_idx[2];
	logic signed [31:0] held_pos[2][3];
	logic signed [31:0] held_uv[2][2];

	triangle_tangent_from_uv i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.vertex_index(vertex_index), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.tex_u(tex_u), .tex_v(tex_v),
		.out_valid(out_valid), .out_ready(out_ready),
		.first_index(first_index), .second_index(second_index),
		.third_index(third_index),
		.tangent_x(tangent_x), .tangent_y(tangent_y), .tangent_z(tangent_z),
		.degenerate(degenerate)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// floor square root, digit by digit
	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] res, bitv;
		res = '0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// update corner state; on a third corner queue the expected tangent
	task automatic predict_tangent(input logic [23:0] idx, input logic [31:0] px,
			input logic [31:0] py, input logic [31:0] pz,
			input logic [31:0] u, input logic [31:0] v);
		logic signed [31:0] p2[3];
		logic signed [33:0] e1[3], e2[3], du1, dv1, du2, dv2;
		logic signed [69:0] det, t[3];
		logic [69:0]        m[3], sum, n, q;
		bit                 neg[3];
		tangent_result_t    r;
		p2[0] = px; p2[1] = py; p2[2] = pz;
		if (corner != SLOT_THIRD) begin
			automatic int s = (corner == SLOT_SECOND) ? 1 : 0;
			held_idx[s] = idx;
			foreach (p2[k]) held_pos[s][k] = p2[k];
			held_uv[s][0] = u;
			held_uv[s][1] = v;
			corner = (s == 1) ? SLOT_THIRD : SLOT_SECOND;
			return;
		end
		corner = SLOT_FIRST;
		for (int k = 0; k < 3; k++) begin
			e1[k] = 34'(held_pos[1][k]) - 34'(held_pos[0][k]);
			e2[k] = 34'(p2[k]) - 34'(held_pos[0][k]);
		end
		du1 = 34'(held_uv[1][0]) - 34'(held_uv[0][0]);
		dv1 = 34'(held_uv[1][1]) - 34'(held_uv[0][1]);
		du2 = 34'($signed(u)) - 34'(held_uv[0][0]);
		dv2 = 34'($signed(v)) - 34'(held_uv[0][1]);
		det = 70'(du1) * 70'(dv2) - 70'(du2) * 70'(dv1);
		for (int k = 0; k < 3; k++) begin
			t[k] = 70'(dv2) * 70'(e1[k]) - 70'(dv1) * 70'(e2[k]);
			m[k] = (t[k] < 0) ? -t[k] : t[k];
			neg[k] = (t[k] != 0) && ((t[k] < 0) != (det < 0));
		end
		r.idx0 = held_idx[0];
		r.idx1 = held_idx[1];
		r.idx2 = idx;
		r.degen = (det == 0) || (m[0] == 0 && m[1] == 0 && m[2] == 0);
		r.tx = '0; r.ty = '0; r.tz = '0;
		if (!r.degen) begin
			while (m[0] >= (70'd1 << 30) || m[1] >= (70'd1 << 30) || m[2] >= (70'd1 << 30))
				for (int k = 0; k < 3; k++) m[k] = m[k] >> 1;
			sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
			n = 70'(floor_sqrt(sum[63:0]));
			if (n == 0) n = 70'd1;
			for (int k = 0; k < 3; k++) begin
				q = (m[k] * 70'd32768 + n) / (70'd2 * n);
				if (q > 70'd16384) q = 70'd16384;
				q = neg[k] ? -q : q;
				if (k == 0) r.tx = q[15:0];
				else if (k == 1) r.ty = q[15:0];
				else r.tz = q[15:0];
			end
		end
		tangent_q = {tangent_q, r};
	endtask

	// offer one vertex, with an optional random gap first
	task automatic send_vertex(input logic [23:0] idx, input logic [31:0] px,
			input logic [31:0] py, input logic [31:0] pz,
			input logic [31:0] u, input logic [31:0] v);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid = 1'b1;
		vertex_index = idx; pos_x = px; pos_y = py; pos_z = pz; tex_u = u; tex_v = v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_tangent(idx, px, py, pz, u, v);
	endtask

	// random vertex; most are small so the tangent math is well conditioned
	task automatic send_random_vertex();
		logic [31:0] f[5];
		if ($urandom_range(0, 3) == 0) begin
			foreach (f[k]) f[k] = $urandom;
		end else begin
			foreach (f[k]) f[k] = $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000;
		end
		send_vertex(24'($urandom), f[0], f[1], f[2], f[3], f[4]);
	endtask

	task automatic test_extremes();
		send_vertex(24'h00_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000);
		send_vertex(24'hFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000);
		send_vertex(24'h55_AAAA, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'h7FFF_FFFF);
		// mirrored uv: negative determinant
		send_vertex(24'hAA_5555, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000);
		send_vertex(24'h00_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
			32'h8000_0000, 32'h7FFF_FFFF);
		send_vertex(24'hFF_FFFE, 32'h0001_0000, 32'h0, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000);
		// a unit tangent with two zero components
		send_vertex(24'd1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
		send_vertex(24'd2, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0);
		send_vertex(24'd3, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000);
	endtask

	task automatic test_degenerate();
		// zero determinant: all uv equal
		send_vertex(24'd10, 32'h0001_0000, 32'h2, 32'h3, 32'h100, 32'h100);
		send_vertex(24'd11, 32'h5, 32'h0007_0000, 32'h9, 32'h100, 32'h100);
		send_vertex(24'd12, 32'hFFFF_0000, 32'h1, 32'h0003_0000, 32'h100, 32'h100);
		// zero tangent: coincident positions, distinct uv
		send_vertex(24'd13, 32'h1234, 32'h5678, 32'h9ABC, 32'h0, 32'h0);
		send_vertex(24'd14, 32'h1234, 32'h5678, 32'h9ABC, 32'h0001_0000, 32'h0);
		send_vertex(24'd15, 32'h1234, 32'h5678, 32'h9ABC, 32'h0, 32'h0001_0000);
	endtask

	task automatic test_random(input int count);
		repeat (count) send_random_vertex();
	endtask

	// receiver holds off for a long stretch while vertices keep coming
	task automatic test_backpressure();
		hold_req = 1'b1;
		repeat (60) send_random_vertex();
	endtask

	// receiver: random stall bursts, or a long hold when asked
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (400) @(negedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(0, 3)) @(negedge clk);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// compare each result transaction with the oldest expected tangent
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (tangent_q.size() == 0) begin
				$display("%0t: unexpected result idx %h %h %h", $time,
					first_index, second_index, third_index);
				err_cnt++;
			end else begin
				automatic tangent_result_t e = tangent_q.pop_front();
				if (first_index !== e.idx0 || second_index !== e.idx1 ||
						third_index !== e.idx2 || degenerate !== e.degen ||
						tangent_x !== e.tx || tangent_y !== e.ty || tangent_z !== e.tz) begin
					$display("%0t: expected idx %h %h %h t %0d %0d %0d dg %b", $time,
						e.idx0, e.idx1, e.idx2, e.tx, e.ty, e.tz, e.degen);
					$display("%0t: actual   idx %h %h %h t %0d %0d %0d dg %b", $time,
						first_index, second_index, third_index,
						tangent_x, tangent_y, tangent_z, degenerate);
					err_cnt++;
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= 20000) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		err_cnt = 0;
		quiet_cycles = 0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		corner = SLOT_FIRST;
		arst_n = 1'b0;
		in_valid = 1'b0;
		vertex_index = '0;
		pos_x = '0; pos_y = '0; pos_z = '0; tex_u = '0; tex_v = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_extremes();
		test_degenerate();
		test_random(600);
		test_backpressure();
		test_random(450);
		idle_on = 1'b0;
		test_random(225);

		@(negedge clk);
		in_valid = 1'b0;
		while (tangent_q.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (err_cnt == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

/* files.f */
+incdir+rtl/core
rtl/core/ttuv_pkg.sv
rtl/core/ttuv_front.sv
rtl/core/ttuv_queue.sv
rtl/core/ttuv_back.sv
rtl/core/triangle_tangent_from_uv.sv
tb/sv/testbench.sv
